@@ hw/rtl/gdno_pkg.sv @@
// Shared types, constants and calendar tables for the Gregorian date normalizer.
// Used by gdno_ctrl, gdno_datapath and gregorian_date_normalize_offset.
// No dependencies.
package gdno_pkg;

   localparam int REQ_DATA_W = 96;
   localparam int RSP_DATA_W = 48;
   localparam int YP_W       = 15;
   localparam int DNUM_W     = 24;
   localparam int DOY_W      = 9;
   localparam int DIST_W     = 22;

   localparam logic OP_SHIFT    = 1'b0;
   localparam logic OP_DISTANCE = 1'b1;

   localparam logic [8:0]      MON_BIAS      = 9'd131;
   localparam logic [7:0]      RECIP_12      = 8'd171;
   localparam logic [14:0]     RECIP_100     = 15'd20972;
   localparam logic [8:0]      DAYS_PER_YEAR = 9'd365;
   localparam logic [YP_W-1:0] YEAR_BIAS     = 15'd389;
   localparam logic [YP_W-1:0] ERA_YEARS     = 15'd400;
   localparam logic [YP_W-1:0] YP_MIN        = 15'd401;
   localparam logic [YP_W-1:0] YP_MAX        = 15'd10399;
   localparam logic [YP_W-1:0] SEARCH_TOP    = 15'h4000;

   typedef struct packed {
      logic load_in;
      logic wrap;
      logic place;
      logic mul;
      logic fwd;
      logic step;
      logic finish;
      logic emit;
      logic sel;
   } gdno_cmd_type;

   typedef struct packed {
      logic op;
      logic last_step;
      logic out_free;
   } gdno_status_type;

   // First day of each month within a year that starts on March 1.
   function automatic logic [DOY_W-1:0] month_start(input logic [3:0] mp);
      logic [DOY_W-1:0] r;
      case (mp)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd31;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd92;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd153;
         4'd6:    r = 9'd184;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd245;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd306;
         4'd11:   r = 9'd337;
         default: r = 9'd0;
      endcase
      return r;
   endfunction

   // Day within the March-based year of the first of a month, month counted from January = 0.
   function automatic logic [DOY_W-1:0] doy_of_month(input logic [3:0] mon0);
      logic [DOY_W-1:0] r;
      case (mon0)
         4'd0:    r = 9'd306;
         4'd1:    r = 9'd337;
         default: r = month_start(mon0 - 4'd2);
      endcase
      return r;
   endfunction

endpackage

@@ hw/rtl/gdno_ctrl.sv @@
// Sequencer of the date normalizer: walks each date through wrap, forward count,
// year search and split, then hands the result to the output register.
// Depends on gdno_pkg.
module gdno_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  gdno_pkg::gdno_status_type status,
   output gdno_pkg::gdno_cmd_type    cmd
);
   import gdno_pkg::*;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b0000000001,
      ST_WRAP  = 10'b0000000010,
      ST_PLACE = 10'b0000000100,
      ST_MUL   = 10'b0000001000,
      ST_FWD   = 10'b0000010000,
      ST_SMUL  = 10'b0000100000,
      ST_SCMP  = 10'b0001000000,
      ST_RMUL  = 10'b0010000000,
      ST_REM   = 10'b0100000000,
      ST_DONE  = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      sel_ff, sel_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         sel_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         sel_ff   <= sel_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      sel_in   = sel_ff;
      case (state_ff)
         ST_IDLE: begin
            sel_in = 1'b0;
            if (req_tvalid) begin
               state_in = ST_WRAP;
            end
         end
         ST_WRAP:  state_in = ST_PLACE;
         ST_PLACE: state_in = ST_MUL;
         ST_MUL:   state_in = ST_FWD;
         ST_FWD:   state_in = ST_SMUL;
         ST_SMUL:  state_in = ST_SCMP;
         ST_SCMP: begin
            state_in = status.last_step ? ST_RMUL : ST_SMUL;
         end
         ST_RMUL:  state_in = ST_REM;
         ST_REM: begin
            if (!sel_ff && status.op == OP_DISTANCE) begin
               sel_in   = 1'b1;
               state_in = ST_WRAP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      cmd         = '0;
      cmd.load_in = (state_ff == ST_IDLE) && req_tvalid;
      cmd.wrap    = (state_ff == ST_WRAP);
      cmd.place   = (state_ff == ST_PLACE);
      cmd.mul     = (state_ff == ST_MUL) || (state_ff == ST_SMUL) || (state_ff == ST_RMUL);
      cmd.fwd     = (state_ff == ST_FWD);
      cmd.step    = (state_ff == ST_SCMP);
      cmd.finish  = (state_ff == ST_REM);
      cmd.emit    = (state_ff == ST_DONE) && status.out_free;
      cmd.sel     = sel_ff;
   end

endmodule

@@ hw/rtl/gdno_datapath.sv @@
// Datapath of the date normalizer: input registers, month wrap, shared start-of-year
// unit, bitwise year search, month split and the result register.
// Depends on gdno_pkg.
module gdno_datapath (
   input  logic                                  clock,
   input  logic                                  reset,
   input  gdno_pkg::gdno_cmd_type                cmd,
   output gdno_pkg::gdno_status_type             status,
   input  logic [gdno_pkg::REQ_DATA_W-1:0]       req_tdata,
   input  logic                                  req_tuser,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gdno_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   output logic                                  rsp_tuser
);
   import gdno_pkg::*;

   logic signed [15:0] req_day, req_off, req_day2;
   logic signed [7:0]  req_mon, req_mon2;
   logic [13:0]        req_yr, req_yr2;

   assign req_day  = req_tdata[15:0];
   assign req_mon  = req_tdata[23:16];
   assign req_yr   = req_tdata[37:24];
   assign req_off  = req_tdata[53:38];
   assign req_day2 = req_tdata[69:54];
   assign req_mon2 = req_tdata[77:70];
   assign req_yr2  = req_tdata[91:78];

   logic               op_ff;
   logic signed [16:0] day1_ff;
   logic signed [15:0] day2_ff;
   logic signed [7:0]  mon1_ff, mon2_ff;
   logic [13:0]        yr1_ff, yr2_ff;

   logic [8:0]         mon_x_ff;
   logic [4:0]         qy_ff;
   logic [DOY_W-1:0]   doy_ff;
   logic [YP_W-1:0]    cand_ff, acc_ff, mask_ff;
   logic [DNUM_W-1:0]  prod_year_ff;
   logic [8:0]         q100_ff;
   logic [6:0]         q400_ff;
   logic [DNUM_W-1:0]  dnum_ff, dnum1_ff;

   logic [4:0]         res_day_ff;
   logic [3:0]         res_mon_ff;
   logic [13:0]        res_yr_ff;
   logic               bad1_ff, bad2_ff;

   logic               rsp_valid_ff;
   logic [4:0]         rsp_day_ff;
   logic [3:0]         rsp_mon_ff;
   logic [13:0]        rsp_yr_ff;
   logic [DIST_W-1:0]  rsp_dist_ff;
   logic               rsp_ovf_ff;

   // Operand selection for the date being worked on.
   logic signed [16:0] raw_day;
   logic signed [7:0]  raw_mon;
   logic [13:0]        raw_yr;

   assign raw_day = cmd.sel ? 17'(day2_ff) : day1_ff;
   assign raw_mon = cmd.sel ? mon2_ff : mon1_ff;
   assign raw_yr  = cmd.sel ? yr2_ff : yr1_ff;

   logic signed [16:0] shifted_day;
   assign shifted_day = 17'(req_day) + 17'(req_off);

   // Month wrap: floor division by twelve through a reciprocal product.
   logic [8:0]  mon_x;
   logic [16:0] prod12;
   assign mon_x  = 9'(raw_mon) + MON_BIAS;
   assign prod12 = 17'(mon_x) * 17'(RECIP_12);

   logic [8:0]      twelve_q, mon_rem;
   logic [3:0]      mon0;
   logic [YP_W-1:0] year_shift;
   assign twelve_q   = {1'b0, qy_ff, 3'b000} + {2'b00, qy_ff, 2'b00};
   assign mon_rem    = mon_x_ff - twelve_q;
   assign mon0       = mon_rem[3:0];
   assign year_shift = {1'b0, raw_yr} + {10'b0, qy_ff} + YEAR_BIAS
                       - {14'b0, (mon0 < 4'd2)};

   // Start-of-year unit: days before March 1 of the biased year held in cand_ff.
   logic [DNUM_W-1:0] prod_year;
   logic [29:0]       prod_cent;
   logic [DNUM_W-1:0] start_day;
   assign prod_year = DNUM_W'(cand_ff) * DNUM_W'(DAYS_PER_YEAR);
   assign prod_cent = 30'(cand_ff) * 30'(RECIP_100);
   assign start_day = prod_year_ff + DNUM_W'(cand_ff[YP_W-1:2])
                      - DNUM_W'(q100_ff) + DNUM_W'(q400_ff);

   logic signed [24:0] dsum;
   assign dsum = $signed({1'b0, start_day}) + $signed({16'b0, doy_ff})
                 + 25'(raw_day) - 25'sd1;

   logic            take;
   logic [YP_W-1:0] acc_next;
   assign take     = (start_day <= dnum_ff);
   assign acc_next = take ? cand_ff : acc_ff;

   // Split of the remaining days into month and day.
   logic [DOY_W-1:0] rem_days, day_tmp;
   logic [3:0]       mp, civ_mon;
   logic [YP_W-1:0]  civ_year, year_unbias;
   logic             year_bad;

   assign rem_days = dnum_ff[DOY_W-1:0] - start_day[DOY_W-1:0];

   always_comb begin
      mp = 4'd0;
      for (int i = 1; i < 12; i++) begin
         if (rem_days >= month_start(4'(i))) begin
            mp = mp + 4'd1;
         end
      end
   end

   assign day_tmp     = rem_days - month_start(mp) + 9'd1;
   assign civ_mon     = (mp < 4'd10) ? mp + 4'd3 : mp - 4'd9;
   assign civ_year    = cand_ff + {14'b0, (mp >= 4'd10)};
   assign year_bad    = (civ_year < YP_MIN) || (civ_year > YP_MAX);
   assign year_unbias = civ_year - ERA_YEARS;

   logic              ovf;
   logic [DNUM_W-1:0] dist_full;
   assign ovf       = bad1_ff || (op_ff == OP_DISTANCE && bad2_ff);
   assign dist_full = (dnum1_ff >= dnum_ff) ? dnum1_ff - dnum_ff : dnum_ff - dnum1_ff;

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         op_ff   <= req_tuser;
         day1_ff <= (req_tuser == OP_SHIFT) ? shifted_day : 17'(req_day);
         mon1_ff <= req_mon;
         yr1_ff  <= req_yr;
         day2_ff <= req_day2;
         mon2_ff <= req_mon2;
         yr2_ff  <= req_yr2;
      end
      if (cmd.wrap) begin
         mon_x_ff <= mon_x;
         qy_ff    <= prod12[15:11];
      end
      if (cmd.place) begin
         doy_ff <= doy_of_month(mon0);
      end
      if (cmd.mul) begin
         prod_year_ff <= prod_year;
         q100_ff      <= prod_cent[29:21];
         q400_ff      <= prod_cent[29:23];
      end
      if (cmd.place) begin
         cand_ff <= year_shift;
      end else if (cmd.fwd) begin
         cand_ff <= SEARCH_TOP;
      end else if (cmd.step) begin
         cand_ff <= acc_next | (mask_ff >> 1);
      end
      if (cmd.fwd) begin
         dnum_ff <= dsum[DNUM_W-1:0];
         acc_ff  <= '0;
         mask_ff <= SEARCH_TOP;
      end else if (cmd.step) begin
         acc_ff  <= acc_next;
         mask_ff <= mask_ff >> 1;
      end
      if (cmd.finish) begin
         if (cmd.sel) begin
            bad2_ff <= year_bad;
         end else begin
            bad1_ff    <= year_bad;
            dnum1_ff   <= dnum_ff;
            res_day_ff <= day_tmp[4:0];
            res_mon_ff <= civ_mon;
            res_yr_ff  <= year_unbias[13:0];
         end
      end
      if (cmd.emit) begin
         rsp_ovf_ff  <= ovf;
         rsp_day_ff  <= ovf ? 5'd0 : res_day_ff;
         rsp_mon_ff  <= ovf ? 4'd0 : res_mon_ff;
         rsp_yr_ff   <= ovf ? 14'd0 : res_yr_ff;
         rsp_dist_ff <= (ovf || op_ff == OP_SHIFT) ? '0 : dist_full[DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign status.op        = op_ff;
   assign status.last_step = mask_ff[0];
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_dist_ff, rsp_yr_ff, rsp_mon_ff, rsp_day_ff};
   assign rsp_tuser  = rsp_ovf_ff;

endmodule

@@ hw/rtl/gregorian_date_normalize_offset.sv @@
// Top level of the Gregorian date normalizer with day offset and day distance.
// Joins the sequencer gdno_ctrl and the datapath gdno_datapath; depends on gdno_pkg.
//
//   channel  direction  tdata (lowest bit up)                              tuser
//   req_     in         day_in 16, month_in 8, year_in 14, offset_days 16,  operation
//                       other_day 16, other_month 8, other_year 14, pad 4
//   rsp_     out        day_out 5, month_out 4, year_out 14,                overflow
//                       distance_days 22, pad 3
//
// Most of the work on each date is the 15-step year search, each step a multiply
// state and then a compare state through the one shared start-of-year multiplier unit.
// A finished result waits in the output register; a new beat is accepted meanwhile
// and holds in its last state only until that register frees.
// Reset is synchronous and active high and clears the sequencer and output valid.
module gregorian_date_normalize_offset (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [gdno_pkg::REQ_DATA_W-1:0]       req_tdata,  // day_in, month_in, year_in,
                                                             // offset_days, other_day,
                                                             // other_month, other_year
   input  logic                                  req_tuser,  // operation
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [gdno_pkg::RSP_DATA_W-1:0]       rsp_tdata,  // day_out, month_out,
                                                             // year_out, distance_days
   output logic                                  rsp_tuser   // overflow
);
   import gdno_pkg::*;

   gdno_cmd_type    cmd;
   gdno_status_type status;

   gdno_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   gdno_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input accepted while a beat is still in work");

   a_overflow_zeroes: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (rsp_tdata[44:0] == 45'd0))
      else $error("overflow result carries nonzero fields");

   a_valid_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |->
         (rsp_tdata[4:0] != 5'd0 && rsp_tdata[8:5] != 4'd0 && rsp_tdata[8:5] <= 4'd12))
      else $error("normal result holds an impossible day or month");

endmodule
